@@ rtl/mwo_pkg.sv @@
// ----------------------------------------------------------------------------
// mwo_pkg: shared types and constants of the morphing wavetable oscillator
// Holds the action codes, register indexes and the item record passed from
// the front part to the back part.
// ----------------------------------------------------------------------------
package mwo_pkg;

	localparam logic ACT_TICK  = 1'b0;
	localparam logic ACT_WRITE = 1'b1;

	localparam logic [1:0] REG_WAVE_SELECT   = 2'd0;
	localparam logic [1:0] REG_BASE_POSITION = 2'd1;
	localparam logic [1:0] REG_VOLUME_LIMIT  = 2'd2;

	localparam int FRAC_BITS = 23;
	localparam int ADDR_W    = 16;

	// One item as queued between front and back part.
	typedef struct packed {
		logic               is_write;
		logic [ADDR_W-1:0]  waddr;
		logic signed [15:0] wdata;
		logic [ADDR_W-1:0]  la_idx;   // left table, current index
		logic [ADDR_W-1:0]  la_nxt;
		logic [ADDR_W-1:0]  ra_idx;
		logic [ADDR_W-1:0]  ra_nxt;
		logic [FRAC_BITS-1:0] frac;
		logic [15:0]        weight;   // 0..32767
		logic [14:0]        factor;   // Q3.12, already limited
	} item_t;

endpackage

@@ rtl/mwo_front.sv @@
// ----------------------------------------------------------------------------
// mwo_front: item intake and classification
// Accepts items, owns the phase accumulator, computes table addresses,
// morph weight and volume factor, and pushes one record per item.
// ----------------------------------------------------------------------------
module mwo_front #(
	parameter int TABLE_LENGTH = 512,
	parameter int MORPH_TABLES = 4,
	parameter int BANDS        = 8,
	parameter int WAVE_SETS    = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                action,
	input  logic [15:0]         write_address,
	input  logic signed [15:0]  write_sample,
	input  logic [31:0]         phase_increment,
	input  logic [2:0]          band_select,
	input  logic signed [15:0]  position_mod,
	input  logic signed [15:0]  volume_mod,
	input  logic [1:0]          wave_select,
	input  logic [15:0]         base_position,
	input  logic [14:0]         volume_factor_limit,
	output logic                push,
	output mwo_pkg::item_t      push_item,
	input  logic                full
);
	import mwo_pkg::*;

	// reciprocal for the integer part wrap; exact for the 10-bit sum
	localparam int          RECIP_SH = 22;
	localparam logic [31:0] RECIP    =
		32'((2**RECIP_SH + TABLE_LENGTH - 1) / TABLE_LENGTH);

	logic [31:0] phase_q;
	logic        accept;

	assign in_stall = full;
	assign accept   = in_valid && !full;
	assign push     = accept;

	// selectors
	logic [31:0] wave_c, band_c;
	always_comb begin
		wave_c = (32'(wave_select) >= 32'(WAVE_SETS)) ? 32'(WAVE_SETS - 1) : 32'(wave_select);
		band_c = (32'(band_select) >= 32'(BANDS)) ? 32'(BANDS - 1) : 32'(band_select);
	end

	// morph position
	logic signed [17:0] pos;
	logic [16:0]        pos_c;
	logic [31:0]        scaled, left, right, weight;
	always_comb begin
		pos = 18'(signed'({2'b00, base_position})) + 18'(position_mod);
		if (pos < 0)
			pos_c = 17'd0;
		else if (pos > 18'sd32768)
			pos_c = 17'd32768;
		else
			pos_c = pos[16:0];
		scaled = 32'(pos_c) * 32'(MORPH_TABLES - 1);
		left   = scaled >> 15;
		weight = scaled & 32'h7FFF;
		right  = left + 32'd1;
		if (left >= 32'(MORPH_TABLES - 1)) begin
			left   = 32'(MORPH_TABLES - 1);
			right  = left;
			weight = 32'd0;
		end
	end

	// indices and addresses; the stored integer part is already wrapped
	logic [31:0] idx, nxt, base, la, ra;
	always_comb begin
		idx  = phase_q >> FRAC_BITS;
		nxt  = (idx + 32'd1 >= 32'(TABLE_LENGTH)) ? 32'd0 : idx + 32'd1;
		base = (wave_c * 32'(BANDS) + band_c) * 32'(MORPH_TABLES);
		la   = (base + left) * 32'(TABLE_LENGTH);
		ra   = (base + right) * 32'(TABLE_LENGTH);
	end

	// volume factor
	logic [15:0] factor;
	always_comb begin
		if (volume_mod > 0)
			factor = 16'd4096 + 16'($unsigned(volume_mod) >> 1);
		else
			factor = 16'((17'sd32768 + 17'(volume_mod)) >>> 3);
		if (factor > 16'(volume_factor_limit))
			factor = 16'(volume_factor_limit);
	end

	always_comb begin
		push_item.is_write = (action == ACT_WRITE);
		push_item.waddr    = write_address;
		push_item.wdata    = write_sample;
		push_item.la_idx   = 16'(la + idx);
		push_item.la_nxt   = 16'(la + nxt);
		push_item.ra_idx   = 16'(ra + idx);
		push_item.ra_nxt   = 16'(ra + nxt);
		push_item.frac     = phase_q[FRAC_BITS-1:0];
		push_item.weight   = 16'(weight);
		push_item.factor   = factor[14:0];
	end

	// advance phase, wrap integer part modulo table length
	logic [32:0] sum;
	logic [9:0]  sum_int;
	logic [31:0] quot;
	logic [32:0] ip;
	always_comb begin
		sum     = 33'(phase_q) + 33'(phase_increment);
		sum_int = sum[32:FRAC_BITS];
		quot    = (32'(sum_int) * RECIP) >> RECIP_SH;
		ip      = 33'(32'(sum_int) - quot * 32'(TABLE_LENGTH));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			phase_q <= '0;
		else if (accept && action == ACT_TICK)
			phase_q <= 32'((ip << FRAC_BITS) | (sum & 33'h7FFFFF));
	end

endmodule

@@ rtl/mwo_queue.sv @@
// ----------------------------------------------------------------------------
// mwo_queue: two-entry queue between front and back part
// Lets the front keep accepting while the back part is busy.
// ----------------------------------------------------------------------------
module mwo_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mwo_pkg::item_t push_item,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output mwo_pkg::item_t head
);
	import mwo_pkg::*;

	item_t      mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;

	assign full      = (cnt_q == 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= ~wr_q;
			if (pop)
				rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

@@ rtl/mwo_back.sv @@
// ----------------------------------------------------------------------------
// mwo_back: table memory and sample datapath
// Sequencer reads four samples over one memory read port, interpolates,
// blends, scales and saturates, then holds the result in an output register.
// ----------------------------------------------------------------------------
module mwo_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               not_empty,
	input  mwo_pkg::item_t     head,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] sample_out
);
	import mwo_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_RD0  = 4'd1;
	localparam logic [3:0] ST_RD1  = 4'd2;
	localparam logic [3:0] ST_RD2  = 4'd3;
	localparam logic [3:0] ST_RD3  = 4'd4;
	localparam logic [3:0] ST_INT  = 4'd5;
	localparam logic [3:0] ST_BLD  = 4'd6;
	localparam logic [3:0] ST_VOL  = 4'd7;
	localparam logic [3:0] ST_SAT  = 4'd8;
	localparam logic [3:0] ST_OUT  = 4'd9;

	logic [3:0] state_q;
	item_t      it_q;

	logic [15:0] mem [65536];
	logic [15:0] rdata_q;
	logic [15:0] raddr;

	logic signed [15:0] l0_q, l1_q, r0_q;
	logic signed [16:0] lv_q, rv_q;
	logic signed [17:0] blend_q;
	logic signed [33:0] y_q;

	always_comb begin
		unique case (state_q)
			ST_RD0:  raddr = it_q.la_idx;
			ST_RD1:  raddr = it_q.la_nxt;
			ST_RD2:  raddr = it_q.ra_idx;
			default: raddr = it_q.ra_nxt;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && not_empty && head.is_write)
			mem[head.waddr] <= head.wdata;
		rdata_q <= mem[raddr];
	end

	assign pop = (state_q == ST_IDLE) && not_empty && (head.is_write || !out_valid);

	logic signed [33:0] bsum;
	assign bsum = 34'(lv_q) * 34'(signed'({2'b0, 16'd32768 - it_q.weight}))
		+ 34'(rv_q) * 34'(signed'({2'b0, it_q.weight}));

	logic signed [33:0] prod;
	assign prod = 34'(blend_q) * 34'(signed'({1'b0, it_q.factor}));

	logic signed [21:0] ysh;
	assign ysh = 22'(y_q >>> 12);

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_RD1: l0_q <= signed'(rdata_q);          // left a
			ST_RD2: l1_q <= signed'(rdata_q);          // left b
			ST_RD3: r0_q <= signed'(rdata_q);          // right a
			ST_BLD: begin
				// rdata_q holds right b until the next item
				lv_q <= 17'(l0_q) + 17'((( 18'(l1_q) - 18'(l0_q))
					* 42'(signed'({1'b0, it_q.frac}))) >>> FRAC_BITS);
				rv_q <= 17'(r0_q) + 17'(((18'(signed'(rdata_q)) - 18'(r0_q))
					* 42'(signed'({1'b0, it_q.frac}))) >>> FRAC_BITS);
			end
			ST_VOL: blend_q <= 18'(bsum >>> 15);
			ST_SAT: y_q <= prod;
			ST_OUT: begin
				if (ysh > 22'sd32767)
					sample_out <= 16'sh7FFF;
				else if (ysh < -22'sd32768)
					sample_out <= -16'sh8000;
				else
					sample_out <= 16'(ysh);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop)
			it_q <= head;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && !out_stall)
				out_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (pop && !head.is_write) state_q <= ST_RD0;
				ST_RD0:  state_q <= ST_RD1;
				ST_RD1:  state_q <= ST_RD2;
				ST_RD2:  state_q <= ST_RD3;
				ST_RD3:  state_q <= ST_INT;
				ST_INT:  state_q <= ST_BLD;
				ST_BLD:  state_q <= ST_VOL;
				ST_VOL:  state_q <= ST_SAT;
				ST_SAT:  state_q <= ST_OUT;
				ST_OUT: begin
					out_valid <= 1'b1;
					state_q   <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/morphing_wavetable_oscillator_unit.sv @@
// ----------------------------------------------------------------------------
// morphing_wavetable_oscillator_unit: morphing wavetable oscillator
// A write item stores one sample into the 64K-entry table memory in the cycle
// it leaves the queue, which it does only while the back part is idle. A tick
// item yields one saturated Q1.15 sample after it leaves the queue, through
// the four reads of the table memory, which has one read port, and the
// interpolate, blend, scale and saturate steps; the next tick leaves the queue
// only once that sample has been taken, so a stalled output holds it back. A
// two-entry queue separates intake from the datapath. The table memory is not
// cleared by reset.
// ----------------------------------------------------------------------------
module morphing_wavetable_oscillator_unit #(
	parameter int TABLE_LENGTH = 512,
	parameter int MORPH_TABLES = 4,
	parameter int BANDS        = 8,
	parameter int WAVE_SETS    = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               action,
	input  logic [15:0]        write_address,
	input  logic signed [15:0] write_sample,
	input  logic [31:0]        phase_increment,
	input  logic [2:0]         band_select,
	input  logic signed [15:0] position_mod,
	input  logic signed [15:0] volume_mod,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] sample_out,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data
);
	import mwo_pkg::*;

	logic [1:0]  wave_select_q;
	logic [15:0] base_position_q;
	logic [14:0] volume_limit_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_select_q   <= 2'd0;
			base_position_q <= 16'd0;
			volume_limit_q  <= 15'd20480;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_WAVE_SELECT:   wave_select_q   <= cfg_data[1:0];
				REG_BASE_POSITION: base_position_q <= cfg_data;
				REG_VOLUME_LIMIT:  volume_limit_q  <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	logic  push, full, pop, not_empty;
	item_t push_item, head;

	mwo_front #(
		.TABLE_LENGTH(TABLE_LENGTH), .MORPH_TABLES(MORPH_TABLES),
		.BANDS(BANDS), .WAVE_SETS(WAVE_SETS)
	) u_front (
		.clk, .arst_n, .in_valid, .in_stall, .action, .write_address,
		.write_sample, .phase_increment, .band_select, .position_mod,
		.volume_mod, .wave_select(wave_select_q), .base_position(base_position_q),
		.volume_factor_limit(volume_limit_q), .push, .push_item, .full
	);

	mwo_queue u_queue (
		.clk, .arst_n, .push, .push_item, .full, .pop, .not_empty, .head
	);

	mwo_back u_back (
		.clk, .arst_n, .not_empty, .head, .pop, .out_valid, .out_stall, .sample_out
	);

endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for morphing_wavetable_oscillator_unit
// Fills the table memory on demand, plays directed and random ticks under
// several register settings and compares every output sample with a local
// fixed-point prediction of interpolation, morph blend and volume scaling.
// ----------------------------------------------------------------------------
module testbench;
	import mwo_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int TLEN     = 512;
	localparam int MORPHS   = 4;
	localparam int NBANDS   = 8;
	localparam int NWAVES   = 4;
	localparam int SETTLE   = 40;

	typedef struct {
		logic               act;
		logic [15:0]        addr;
		logic signed [15:0] wdata;
		logic [31:0]        inc;
		logic [2:0]         band;
		logic signed [15:0] pmod;
		logic signed [15:0] vmod;
	} osc_item_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               action = ACT_TICK;
	logic [15:0]        write_address = '0;
	logic signed [15:0] write_sample = '0;
	logic [31:0]        phase_increment = '0;
	logic [2:0]         band_select = '0;
	logic signed [15:0] position_mod = '0;
	logic signed [15:0] volume_mod = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [15:0] sample_out;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [1:0]         cfg_index = '0;
	logic [15:0]        cfg_data = '0;

	// local copy of block state
	logic [15:0] tbl_mem [65536];
	bit          tbl_written [65536];
	logic [31:0] osc_phase;
	logic [1:0]  wave_sel;
	logic [15:0] base_pos;
	logic [14:0] vol_limit;

	logic signed [15:0] expected_samples [$];
	int  errors = 0;
	bit  quiet = 1'b0;
	int  stall_left = 0;

	morphing_wavetable_oscillator_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .write_address(write_address), .write_sample(write_sample),
		.phase_increment(phase_increment), .band_select(band_select),
		.position_mod(position_mod), .volume_mod(volume_mod),
		.out_valid(out_valid), .out_stall(out_stall), .sample_out(sample_out),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("[morphing_wavetable_oscillator_unit] ERROR");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch: %s", msg);
		errors++;
	endtask

	// table pair and weight from the morph position
	task automatic morph_select(input logic signed [15:0] pmod,
			output int left, output int right, output int w);
		int pos;
		int scaled;
		pos = int'(base_pos) + int'(pmod);
		if (pos < 0) pos = 0;
		if (pos > 32768) pos = 32768;
		scaled = pos * (MORPHS - 1);
		left = scaled >> 15;
		w = scaled & 32'h7FFF;
		right = left + 1;
		if (left >= MORPHS - 1) begin
			left = MORPHS - 1;
			right = left;
			w = 0;
		end
	endtask

	// the four table addresses a tick reads at the current phase
	task automatic tick_addresses(input logic [2:0] band, input logic signed [15:0] pmod,
			output logic [15:0] a [4], output int w);
		int left, right, idx, nxt, wv, bd, bse;
		morph_select(pmod, left, right, w);
		wv = (wave_sel >= NWAVES) ? NWAVES - 1 : wave_sel;
		bd = (band >= NBANDS) ? NBANDS - 1 : band;
		idx = (osc_phase >> FRAC_BITS) % TLEN;
		nxt = (idx + 1 >= TLEN) ? 0 : idx + 1;
		bse = (wv * NBANDS + bd) * MORPHS;
		a[0] = 16'((bse + left) * TLEN + idx);
		a[1] = 16'((bse + left) * TLEN + nxt);
		a[2] = 16'((bse + right) * TLEN + idx);
		a[3] = 16'((bse + right) * TLEN + nxt);
	endtask

	task automatic predict_item(input osc_item_t it);
		logic [15:0] a [4];
		int w;
		longint l0, l1, r0, r1, lv, rv, frac, blend, factor, y;
		logic [63:0] sum;
		logic [63:0] ip;
		if (it.act == ACT_WRITE) begin
			tbl_mem[it.addr] = it.wdata;
			tbl_written[it.addr] = 1'b1;
			return;
		end
		tick_addresses(it.band, it.pmod, a, w);
		l0 = longint'($signed(tbl_mem[a[0]]));
		l1 = longint'($signed(tbl_mem[a[1]]));
		r0 = longint'($signed(tbl_mem[a[2]]));
		r1 = longint'($signed(tbl_mem[a[3]]));
		frac = longint'(osc_phase[FRAC_BITS-1:0]);
		lv = l0 + (((l1 - l0) * frac) >>> FRAC_BITS);
		rv = r0 + (((r1 - r0) * frac) >>> FRAC_BITS);
		blend = (lv * (32768 - w) + rv * w) >>> 15;
		if (it.vmod > 0)
			factor = 4096 + (longint'(it.vmod) >>> 1);
		else
			factor = (32768 + longint'(it.vmod)) >>> 3;
		if (factor > longint'(vol_limit)) factor = longint'(vol_limit);
		y = (blend * factor) >>> 12;
		if (y > 32767) y = 32767;
		if (y < -32768) y = -32768;
		expected_samples.push_back(16'(y));
		sum = {32'b0, osc_phase} + {32'b0, it.inc};
		ip = (sum >> FRAC_BITS) % TLEN;
		osc_phase = 32'((ip << FRAC_BITS) | (sum & 64'h7FFFFF));
	endtask

	task automatic send_item(input osc_item_t it);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid        <= 1'b1;
		action          <= it.act;
		write_address   <= it.addr;
		write_sample    <= it.wdata;
		phase_increment <= it.inc;
		band_select     <= it.band;
		position_mod    <= it.pmod;
		volume_mod      <= it.vmod;
		// stall only moves at a rising edge, so the falling edge shows the next one
		@(negedge clk);
		while (in_stall) @(negedge clk);
		@(posedge clk);
		predict_item(it);
	endtask

	task automatic send_write(input logic [15:0] addr, input logic signed [15:0] data);
		osc_item_t it;
		it.act = ACT_WRITE;
		it.addr = addr;
		it.wdata = data;
		it.inc = $urandom;
		it.band = $urandom;
		it.pmod = $urandom;
		it.vmod = $urandom;
		send_item(it);
	endtask

	// fill any entry the tick would read that holds no sample yet
	task automatic send_tick(input logic [31:0] inc, input logic [2:0] band,
			input logic signed [15:0] pmod, input logic signed [15:0] vmod);
		osc_item_t it;
		logic [15:0] a [4];
		int w;
		tick_addresses(band, pmod, a, w);
		for (int k = 0; k < 4; k++)
			if (!tbl_written[a[k]]) send_write(a[k], $urandom);
		it.act = ACT_TICK;
		it.addr = $urandom;
		it.wdata = $urandom;
		it.inc = inc;
		it.band = band;
		it.pmod = pmod;
		it.vmod = vmod;
		send_item(it);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_samples.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		while (!cfg_ready) @(negedge clk);
		@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_WAVE_SELECT:   wave_sel = data[1:0];
			REG_BASE_POSITION: base_pos = data;
			REG_VOLUME_LIMIT:  vol_limit = data[14:0];
			default: ;
		endcase
	endtask

	task automatic set_regs(input logic [1:0] wv, input logic [15:0] bp, input logic [14:0] lim);
		write_reg(REG_WAVE_SELECT, {14'b0, wv});
		write_reg(REG_BASE_POSITION, bp);
		write_reg(REG_VOLUME_LIMIT, {1'b0, lim});
	endtask

	task automatic random_tick();
		logic [31:0] inc;
		case ($urandom_range(0, 3))
			0: inc = $urandom;
			1: inc = $urandom_range(0, 32'h00FF_FFFF);
			2: inc = {$urandom_range(0, 511), 23'($urandom)};
			default: inc = ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : 32'h0;
		endcase
		send_tick(inc, $urandom, $urandom, $urandom);
	endtask

	task automatic test_reset_state();
		send_tick(32'h0, 3'd0, 16'sd0, 16'sd0);
		send_tick(32'h0080_0000, 3'd0, 16'sd0, 16'sd0);
		send_tick(32'h0040_0000, 3'd7, 16'sd0, 16'sd32767);
	endtask

	task automatic test_directed();
		set_regs(2'd3, 16'd32768, 15'd20480);
		// top morph position: right table equals left, weight zero
		send_tick(32'h0123_4567, 3'd7, 16'sd0, 16'sd32767);
		send_tick(32'hFFFF_FFFF, 3'd7, 16'sd32767, -16'sd32768);
		send_tick(32'h0000_0001, 3'd0, -16'sd32768, 16'sd1);
		send_tick(32'h8000_0000, 3'd4, 16'sd16384, -16'sd1);
		// store full-scale samples at both ends of the table memory, then tick at high volume
		send_write(16'hFFFF, 16'sh7FFF);
		send_write(16'h0000, -16'sh8000);
		for (int k = 0; k < 4; k++)
			send_tick(32'h00C0_0000, 3'd7, 16'sd0, 16'sd32767);
		set_regs(2'd0, 16'd0, 15'd0);
		send_tick(32'h0, 3'd0, 16'sd100, 16'sd32767);
		send_tick(32'h0, 3'd0, -16'sd100, -16'sd32768);
		set_regs(2'd1, 16'd16384, 15'h7FFF);
		send_tick(32'h0, 3'd2, 16'sd0, 16'sd32767);
		send_tick(32'h00FF_FFFF, 3'd5, -16'sd16384, 16'sd0);
	endtask

	task automatic test_random();
		logic [14:0] lim;
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: lim = 15'd20480;
				1: lim = 15'd0;
				2: lim = 15'h7FFF;
				default: lim = $urandom_range(0, 20480);
			endcase
			set_regs($urandom, (ph == 3) ? 16'hFFFF : 16'($urandom_range(0, 32768)), lim);
			for (int k = 0; k < 30; k++) begin
				if ($urandom_range(0, 4) == 0) send_write($urandom, $urandom);
				else random_tick();
			end
		end
	endtask

	task automatic test_drain_pause();
		for (int k = 0; k < 20; k++) random_tick();
		in_valid <= 1'b0;
		while (expected_samples.size() != 0) @(posedge clk);
		for (int k = 0; k < 20; k++) random_tick();
	endtask

	task automatic test_no_idling();
		set_regs(2'd2, 16'd24576, 15'd20480);
		quiet = 1'b1;
		for (int k = 0; k < 100; k++) random_tick();
	endtask

	// output side: raise stall in short random bursts
	always @(posedge clk) begin
		if (quiet) begin
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if ($urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 2);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// an item seen here with stall low is taken at the next rising edge
	always @(negedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_samples.size() == 0) begin
				report_mismatch($sformatf("unexpected sample %0d", sample_out));
			end else begin
				logic signed [15:0] exp_s;
				exp_s = expected_samples.pop_front();
				if (sample_out !== exp_s)
					report_mismatch($sformatf("sample_out %0d, want %0d", sample_out, exp_s));
			end
		end
	end

	initial begin
		osc_phase = '0;
		wave_sel  = '0;
		base_pos  = '0;
		vol_limit = 15'd20480;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_directed();
		test_random();
		test_drain_pause();
		test_no_idling();
		wait_idle();
		if (errors == 0)
			$display("[morphing_wavetable_oscillator_unit] OK");
		else
			$display("[morphing_wavetable_oscillator_unit] ERROR");
		$finish;
	end

endmodule
